@@ src/etmc_pkg.sv @@
// Shared types and constants for the exposure timer mode controller.
// No dependencies; imported by the top level and by its port checker.
`timescale 1ns / 1ps

package etmc_pkg;

    // Operating modes, in the order the user steps through them
    typedef enum logic [3:0] {
        MODE_SHOW_MIN  = 4'd0,
        MODE_EDIT_MIN  = 4'd1,
        MODE_SHOW_SPD  = 4'd2,
        MODE_EDIT_SPD  = 4'd3,
        MODE_PREPARE   = 4'd4,
        MODE_COUNTDOWN = 4'd5,
        MODE_PAUSED    = 4'd6,
        MODE_DONE      = 4'd7,
        MODE_IDLE      = 4'd8
    } mode_t;

    // Configuration register indexes
    localparam logic [2:0] REG_DURATION_LOW   = 3'd0;
    localparam logic [2:0] REG_DURATION_HIGH  = 3'd1;
    localparam logic [2:0] REG_SPEED_INCR     = 3'd2;
    localparam logic [2:0] REG_MAX_STEP_RATE  = 3'd3;
    localparam logic [2:0] REG_TICK_PERIOD    = 3'd4;

    // Encoder and button codes
    localparam logic [1:0] ENC_CW     = 2'b01;
    localparam logic [1:0] ENC_CCW    = 2'b11;
    localparam logic [1:0] BTN_CLICK  = 2'd1;
    localparam logic [1:0] BTN_LONG   = 2'd2;

    // Beat widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;

    localparam logic [6:0]  SPEED_MAX      = 7'd100;
    localparam logic [22:0] MS_PER_MINUTE  = 23'd60000;
    localparam logic [7:0]  SECS_PER_MIN   = 8'd60;

    // Reciprocal constants: floor(x / d) = (x * RECIP) >> SHIFT, exact over
    // the value ranges used here
    localparam logic [17:0] RECIP_100   = 18'd167773;    // x < 2^17, shift 24
    localparam int          SHIFT_100   = 24;
    localparam logic [23:0] RECIP_1000  = 24'd8589935;   // x < 2^23, shift 33
    localparam int          SHIFT_1000  = 33;
    localparam logic [14:0] RECIP_60    = 15'd17477;     // x < 2^14, shift 20
    localparam int          SHIFT_60    = 20;

    // Per-poll status as it leaves the mode machine
    typedef struct packed {
        mode_t        mode;
        logic [6:0]   minutes;
        logic [6:0]   speed;
        logic         motor;
        logic [22:0]  remaining;
        logic         lamp;
        logic         screen;
        logic         rate_upd;
    } poll_status_t;

endpackage

@@ src/exposure_timer_mode_controller_unit.sv @@
// Exposure timer mode controller: mode machine, countdown and display math.
// Depends on etmc_pkg for the mode type, codes and reciprocal constants.
`timescale 1ns / 1ps

// Usage
//   Slave stream s_*: one poll per beat. tdata carries the millisecond time,
//   the encoder detent and the button event.
//   Master stream m_*: one result beat per poll with the mode, the settings,
//   the step rate, the remaining time, its minute and second digits and the
//   lamp and display flags.
//   Configuration: cfg_we writes cfg_data into register cfg_index;
//   write only while no poll is in flight.
// Timing
//   One poll per cycle is taken and delivered in steady state while m_tready
//   stays high. The mode machine updates all state in the single cycle a poll
//   leaves the input register; the three stages after the mode machine hold
//   the rate scaling and the two constant divisions that split the remaining
//   time into minutes and seconds.
// Reset and stall
//   rst_n clears all stage valids and loads the state and configuration
//   defaults. When m_tready is low the result holds and the stages behind
//   it keep filling; s_tready falls only once every stage holds a poll.
module exposure_timer_mode_controller_unit
    import etmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // now_ms[31:0], encoder_move[33:32], button_event[35:34], zero[39:36]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // mode_now[3:0], minutes_set[10:4], speed_percent[17:11], step_rate[27:18],
    // motor_running[28], remaining_ms[51:29], shown_minutes[57:52],
    // shown_seconds[63:58], leds_on[64], display_on[65], zero[71:66]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    // Configuration registers
    logic [6:0]   dur_low_reg;
    logic [6:0]   dur_high_reg;
    logic [6:0]   speed_incr_reg;
    logic [9:0]   max_rate_reg;
    logic [15:0]  tick_period_reg;

    // Controller state
    mode_t        mode_reg, mode_next, mode_mid;
    logic [6:0]   minutes_reg, minutes_next;
    logic [6:0]   speed_reg, speed_next;
    logic [22:0]  remaining_reg, remaining_next;
    logic [31:0]  last_update_reg, last_update_next;
    logic         lamp_reg, lamp_next;
    logic         screen_reg, screen_next;
    logic         rate_upd;

    // Pipeline stages
    logic         s1_valid_reg;
    logic [31:0]  s1_now_reg;
    logic [1:0]   s1_enc_reg;
    logic [1:0]   s1_btn_reg;

    logic         s2_valid_reg;
    poll_status_t s2_reg;

    logic         s3_valid_reg;
    poll_status_t s3_reg;
    logic [16:0]  s3_rate_prod_reg;
    logic [13:0]  s3_secs_reg;

    logic         s4_valid_reg;
    poll_status_t s4_reg;
    logic [9:0]   s4_rate_reg;
    logic [13:0]  s4_secs_reg;
    logic [7:0]   s4_mins_reg;

    logic         out_valid_reg;
    poll_status_t out_reg;
    logic [9:0]   rate_reg;
    logic [5:0]   shown_min_reg;
    logic [5:0]   shown_sec_reg;

    logic         out_free, s4_free, s3_free, s2_free, s1_free;

    // Datapath intermediates
    logic              mv_up, mv_dn, moved;
    logic [31:0]       passed;
    logic signed [8:0] min_sum;
    logic [6:0]        min_wrapped;
    logic signed [8:0] spd_delta;
    logic signed [8:0] spd_sum;
    logic [6:0]        spd_wrapped;
    logic [6:0]        spd_keep;
    logic [22:0]       prep_remaining;
    logic [34:0]       rate_scaled;
    logic [46:0]       secs_scaled;
    logic [28:0]       mins_scaled;
    logic [13:0]       mins_times60;
    logic [13:0]       sec_digit_wide;
    logic [7:0]        min_digit_wide;

    // Stage handshakes: a stage moves when the one ahead can take its beat
    assign out_free = !out_valid_reg || m_tready;
    assign s4_free  = !s4_valid_reg  || out_free;
    assign s3_free  = !s3_valid_reg  || s4_free;
    assign s2_free  = !s2_valid_reg  || s3_free;
    assign s1_free  = !s1_valid_reg  || s2_free;
    assign s_tready = s1_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_low_reg     <= 7'd1;
            dur_high_reg    <= 7'd90;
            speed_incr_reg  <= 7'd10;
            max_rate_reg    <= 10'd500;
            tick_period_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DURATION_LOW:  dur_low_reg     <= cfg_data[6:0];
                REG_DURATION_HIGH: dur_high_reg    <= cfg_data[6:0];
                REG_SPEED_INCR:    speed_incr_reg  <= cfg_data[6:0];
                REG_MAX_STEP_RATE: max_rate_reg    <= cfg_data[9:0];
                REG_TICK_PERIOD:   tick_period_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && s_tvalid)
        begin
            s1_now_reg <= s_tdata[31:0];
            s1_enc_reg <= s_tdata[33:32];
            s1_btn_reg <= s_tdata[35:34];
        end
    end

    // Encoder, wrap and countdown arithmetic
    always_comb
    begin
        mv_up  = (s1_enc_reg == ENC_CW);
        mv_dn  = (s1_enc_reg == ENC_CCW);
        moved  = mv_up || mv_dn;
        passed = s1_now_reg - last_update_reg;

        min_sum = $signed({2'b00, minutes_reg}) + (mv_up ? 9'sd1 : (mv_dn ? -9'sd1 : 9'sd0));
        if (min_sum < $signed({2'b00, dur_low_reg}))
            min_wrapped = dur_high_reg;
        else if (min_sum > $signed({2'b00, dur_high_reg}))
            min_wrapped = dur_low_reg;
        else
            min_wrapped = min_sum[6:0];

        if (mv_up)
            spd_delta = $signed({2'b00, speed_incr_reg});
        else if (mv_dn)
            spd_delta = -$signed({2'b00, speed_incr_reg});
        else
            spd_delta = 9'sd0;
        spd_sum = $signed({2'b00, speed_reg}) + spd_delta;
        if (spd_sum < 9'sd0)
            spd_wrapped = SPEED_MAX;
        else if (spd_sum > $signed({2'b00, SPEED_MAX}))
            spd_wrapped = 7'd0;
        else
            spd_wrapped = spd_sum[6:0];

        // Entering speed edit re-applies the wrap without a step
        spd_keep = (speed_reg > SPEED_MAX) ? 7'd0 : speed_reg;

        prep_remaining = {16'd0, minutes_reg} * MS_PER_MINUTE;
    end

    // Mode machine: next state
    always_comb
    begin
        mode_mid         = mode_reg;
        minutes_next     = minutes_reg;
        speed_next       = speed_reg;
        remaining_next   = remaining_reg;
        last_update_next = last_update_reg;
        lamp_next        = lamp_reg;
        screen_next      = screen_reg;
        rate_upd         = 1'b0;

        unique case (mode_reg)
            MODE_SHOW_MIN:
            begin
                mode_mid = MODE_EDIT_MIN;
            end
            MODE_EDIT_MIN:
            begin
                if (moved)
                    minutes_next = min_wrapped;
            end
            MODE_SHOW_SPD:
            begin
                speed_next = spd_keep;
                rate_upd   = 1'b1;
                mode_mid   = MODE_EDIT_SPD;
            end
            MODE_EDIT_SPD:
            begin
                if (moved)
                begin
                    speed_next = spd_wrapped;
                    rate_upd   = 1'b1;
                end
            end
            MODE_PREPARE:
            begin
                remaining_next   = prep_remaining;
                last_update_next = s1_now_reg;
                lamp_next        = 1'b1;
                mode_mid         = MODE_COUNTDOWN;
            end
            MODE_COUNTDOWN:
            begin
                if (moved)
                begin
                    speed_next = spd_wrapped;
                    rate_upd   = 1'b1;
                end
                if (moved || passed >= {16'd0, tick_period_reg})
                begin
                    last_update_next = s1_now_reg;
                    if (passed < {9'd0, remaining_reg})
                        remaining_next = remaining_reg - passed[22:0];
                    else
                        mode_mid = MODE_DONE;
                end
            end
            MODE_DONE:
            begin
                screen_next = 1'b0;
                lamp_next   = 1'b0;
                mode_mid    = MODE_IDLE;
            end
            default:
            begin
                mode_mid = mode_reg;
            end
        endcase

        // Button acts on the mode the machine just produced
        mode_next = mode_mid;
        if (s1_btn_reg == BTN_CLICK)
        begin
            unique case (mode_mid)
                MODE_EDIT_MIN:  mode_next = MODE_SHOW_SPD;
                MODE_EDIT_SPD:  mode_next = MODE_PREPARE;
                MODE_COUNTDOWN: mode_next = MODE_PAUSED;
                MODE_PAUSED:
                begin
                    last_update_next = s1_now_reg;
                    mode_next        = MODE_COUNTDOWN;
                end
                MODE_IDLE:
                begin
                    mode_next   = MODE_SHOW_MIN;
                    screen_next = 1'b1;
                end
                default:        mode_next = mode_mid;
            endcase
        end
        else if (s1_btn_reg == BTN_LONG)
        begin
            mode_next   = MODE_SHOW_MIN;
            screen_next = 1'b1;
        end
    end

    // Commit state as a poll moves into the status stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_SHOW_MIN;
            minutes_reg     <= 7'd15;
            speed_reg       <= 7'd20;
            remaining_reg   <= 23'd0;
            last_update_reg <= 32'd0;
            lamp_reg        <= 1'b0;
            screen_reg      <= 1'b1;
        end
        else if (s1_valid_reg && s2_free)
        begin
            mode_reg        <= mode_next;
            minutes_reg     <= minutes_next;
            speed_reg       <= speed_next;
            remaining_reg   <= remaining_next;
            last_update_reg <= last_update_next;
            lamp_reg        <= lamp_next;
            screen_reg      <= screen_next;
        end
    end

    // Status stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_reg.mode      <= mode_next;
            s2_reg.minutes   <= minutes_next;
            s2_reg.speed     <= speed_next;
            s2_reg.motor     <= (mode_reg == MODE_EDIT_SPD) || (mode_reg == MODE_COUNTDOWN);
            s2_reg.remaining <= remaining_next;
            s2_reg.lamp      <= lamp_next;
            s2_reg.screen    <= screen_next;
            s2_reg.rate_upd  <= rate_upd;
        end
    end

    // Product stage: speed times max rate, remaining scaled toward seconds
    assign secs_scaled = {24'd0, s2_reg.remaining} * {23'd0, RECIP_1000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_free)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_free && s2_valid_reg)
        begin
            s3_reg           <= s2_reg;
            s3_rate_prod_reg <= {10'd0, s2_reg.speed} * {7'd0, max_rate_reg};
            s3_secs_reg      <= secs_scaled[SHIFT_1000 +: 14];
        end
    end

    // Quotient stage: rate over one hundred, seconds over sixty
    assign rate_scaled = {18'd0, s3_rate_prod_reg} * {17'd0, RECIP_100};
    assign mins_scaled = {15'd0, s3_secs_reg} * {14'd0, RECIP_60};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (s4_free)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s4_free && s3_valid_reg)
        begin
            s4_reg      <= s3_reg;
            s4_rate_reg <= rate_scaled[SHIFT_100 +: 10];
            s4_secs_reg <= s3_secs_reg;
            s4_mins_reg <= mins_scaled[SHIFT_60 +: 8];
        end
    end

    // Digit split: seconds remainder and minutes modulo sixty
    always_comb
    begin
        mins_times60   = ({6'd0, s4_mins_reg} << 6) - ({6'd0, s4_mins_reg} << 2);
        sec_digit_wide = s4_secs_reg - mins_times60;
        if (s4_mins_reg >= (SECS_PER_MIN << 1))
            min_digit_wide = s4_mins_reg - (SECS_PER_MIN << 1);
        else if (s4_mins_reg >= SECS_PER_MIN)
            min_digit_wide = s4_mins_reg - SECS_PER_MIN;
        else
            min_digit_wide = s4_mins_reg;
    end

    // Result register; the step rate holds between speed changes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rate_reg      <= 10'd0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s4_valid_reg;
            if (s4_valid_reg && s4_reg.rate_upd)
                rate_reg <= s4_rate_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s4_valid_reg)
        begin
            out_reg       <= s4_reg;
            shown_min_reg <= min_digit_wide[5:0];
            shown_sec_reg <= sec_digit_wide[5:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_reg.screen,
                       out_reg.lamp,
                       shown_sec_reg,
                       shown_min_reg,
                       out_reg.remaining,
                       out_reg.motor,
                       rate_reg,
                       out_reg.speed,
                       out_reg.minutes,
                       out_reg.mode};

endmodule

@@ src/etmc_checker.sv @@
// Port-level checks for the exposure timer mode controller.
// Depends on etmc_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module etmc_checker
    import etmc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // Hold a stalled result beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Display digits stay below sixty
    a_digits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[57:52] < 6'd60) && (m_tdata[63:58] < 6'd60))
        else $error("display digit out of range");

    // Only the defined mode codes are reported
    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= MODE_IDLE)
        else $error("undefined mode reported");

    // A dark display only follows a finished run: idle with the lamp off
    a_dark_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[65] |-> m_tdata[3:0] == MODE_IDLE && !m_tdata[64])
        else $error("display off outside idle or with lamp on");

endmodule

bind exposure_timer_mode_controller_unit etmc_checker u_etmc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
